/* rtl/modexp_pkg.sv */
`timescale 1ns / 1ps

package modexp_pkg;

   // register index, taken from the address bits above the word offset
   typedef enum logic [0:0] {
      REG_EXPONENT = 1'b0,
      REG_MODULUS  = 1'b1
   } reg_index_type;

   // status of the shared modular multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

/* rtl/modexp_csr.sv */
`timescale 1ns / 1ps

module modexp_csr #(
   parameter int WORD_BITS = 32,
   localparam int DATA_W = (WORD_BITS > 32) ? 64 : 32,
   localparam int STRIDE_BITS = (WORD_BITS > 32) ? 3 : 2,
   localparam int ADDR_W = STRIDE_BITS + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [DATA_W-1:0]    pwdata,
   output logic [DATA_W-1:0]    prdata,
   output logic [WORD_BITS-1:0] exponent,
   output logic [WORD_BITS-1:0] modulus
);
   import modexp_pkg::*;

   logic [WORD_BITS-1:0] exponent_ff;
   logic [WORD_BITS-1:0] modulus_ff;
   reg_index_type        index;
   logic                 write_en;

   assign index    = reg_index_type'(paddr[STRIDE_BITS]);
   assign write_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= WORD_BITS'(1);
         modulus_ff  <= WORD_BITS'(1);
      end else if (write_en) begin
         unique case (index)
            REG_EXPONENT: exponent_ff <= pwdata[WORD_BITS-1:0];
            REG_MODULUS:  modulus_ff  <= pwdata[WORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_EXPONENT: prdata = DATA_W'(exponent_ff);
         REG_MODULUS:  prdata = DATA_W'(modulus_ff);
         default:      prdata = '0;
      endcase
   end

   assign exponent = exponent_ff;
   assign modulus  = modulus_ff;

endmodule

/* rtl/modexp_mulmod.sv */
`timescale 1ns / 1ps

// Shift-add modular multiplier: one bit of b per cycle, msb first.
// acc = (2*acc + b_bit*a) mod m, with a < m and acc < m, so the sum stays below 3m.
module modexp_mulmod #(
   parameter int WORD_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [WORD_BITS-1:0]      a,
   input  logic [WORD_BITS-1:0]      b,
   input  logic [WORD_BITS-1:0]      m,
   output modexp_pkg::mm_status_type status,
   output logic [WORD_BITS-1:0]      result
);
   import modexp_pkg::*;

   localparam int CNT_W = $clog2(WORD_BITS);
   localparam int SUM_W = WORD_BITS + 2;

   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] a_ff;
   logic [WORD_BITS-1:0] b_ff;
   logic [WORD_BITS-1:0] m_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] m_one;
   logic [SUM_W-1:0] m_two;
   logic [SUM_W-1:0] less_one;
   logic [SUM_W-1:0] less_two;

   always_comb begin
      m_one    = {2'b00, m_ff};
      m_two    = {1'b0, m_ff, 1'b0};
      sum      = {1'b0, acc_ff, 1'b0} + (b_ff[WORD_BITS-1] ? {2'b00, a_ff} : '0);
      less_one = sum - m_one;
      less_two = sum - m_two;
      priority if (sum >= m_two) begin
         acc_in = less_two[WORD_BITS-1:0];
      end else if (sum >= m_one) begin
         acc_in = less_one[WORD_BITS-1:0];
      end else begin
         acc_in = sum[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            acc_ff   <= '0;
            a_ff     <= a;
            b_ff     <= b;
            m_ff     <= m;
            count_ff <= CNT_W'(WORD_BITS - 1);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            acc_ff <= acc_in;
            b_ff   <= b_ff << 1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff - 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = acc_ff;

endmodule

/* rtl/modular_exponentiation.sv */
`timescale 1ns / 1ps

// Modular exponentiation: each accepted req word returns value_in^exponent mod modulus
// on the rsp channel, exponent and modulus being the two registers of the APB port
// (exponent at offset 0, modulus at offset 4; 0 and 8 when WORD_BITS exceeds 32).
// A zero modulus returns 0 with rsp_modulus_error set; a zero exponent returns 1.
// The work runs by square-and-multiply on one shared shift-add modular multiplier
// that retires one multiplier bit per cycle; an item with a zero modulus or
// exponent does not use the multiplier. req_ready is low while an item is in
// work; a finished word waits in the output register and does not block
// acceptance of the next item.
module modular_exponentiation #(
   parameter int WORD_BITS = 32,
   localparam int DATA_W = (WORD_BITS > 32) ? 64 : 32,
   localparam int ADDR_W = ((WORD_BITS > 32) ? 3 : 2) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_BITS-1:0] req_value_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_BITS-1:0] rsp_value_out,
   output logic                 rsp_modulus_error,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [DATA_W-1:0]    pwdata,
   output logic [DATA_W-1:0]    prdata,
   output logic                 pready
);
   import modexp_pkg::*;

   localparam int CNT_W = $clog2(WORD_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_REDUCE,
      PH_SQUARE,
      PH_MULT
   } phase_type;

   logic [WORD_BITS-1:0] exponent;
   logic [WORD_BITS-1:0] modulus;
   logic [WORD_BITS-1:0] one_mod;
   mm_status_type        mm_status;
   logic [WORD_BITS-1:0] mm_result;

   state_type            state_ff;
   phase_type            phase_ff;
   logic                 start_ff;
   logic [WORD_BITS-1:0] op_a_ff;
   logic [WORD_BITS-1:0] op_b_ff;
   logic [WORD_BITS-1:0] base_ff;
   logic [WORD_BITS-1:0] acc_ff;
   logic                 err_ff;
   logic [CNT_W-1:0]     bit_ff;
   logic                 rsp_valid_ff;
   logic [WORD_BITS-1:0] rsp_value_ff;
   logic                 rsp_error_ff;

   modexp_csr #(
      .WORD_BITS(WORD_BITS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .exponent (exponent),
      .modulus  (modulus)
   );

   modexp_mulmod #(
      .WORD_BITS(WORD_BITS)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .a      (op_a_ff),
      .b      (op_b_ff),
      .m      (modulus),
      .status (mm_status),
      .result (mm_result)
   );

   // 1 mod m
   assign one_mod   = (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
   assign req_ready = (state_ff == ST_IDLE) && !mm_status.busy;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_REDUCE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  bit_ff <= CNT_W'(WORD_BITS - 1);
                  priority if (modulus == '0) begin
                     acc_ff   <= '0;
                     err_ff   <= 1'b1;
                     state_ff <= ST_DONE;
                  end else if (exponent == '0) begin
                     acc_ff   <= WORD_BITS'(1);
                     err_ff   <= 1'b0;
                     state_ff <= ST_DONE;
                  end else begin
                     // base = value mod m, as value * (1 mod m)
                     acc_ff   <= one_mod;
                     err_ff   <= 1'b0;
                     op_a_ff  <= one_mod;
                     op_b_ff  <= req_value_in;
                     start_ff <= 1'b1;
                     phase_ff <= PH_REDUCE;
                     state_ff <= ST_WAIT;
                  end
               end
            end
            ST_WAIT: begin
               if (mm_status.done) begin
                  unique case (phase_ff)
                     PH_REDUCE: begin
                        base_ff  <= mm_result;
                        op_a_ff  <= acc_ff;
                        op_b_ff  <= acc_ff;
                        start_ff <= 1'b1;
                        phase_ff <= PH_SQUARE;
                     end
                     PH_SQUARE: begin
                        acc_ff <= mm_result;
                        priority if (exponent[bit_ff]) begin
                           op_a_ff  <= mm_result;
                           op_b_ff  <= base_ff;
                           start_ff <= 1'b1;
                           phase_ff <= PH_MULT;
                        end else if (bit_ff == '0) begin
                           state_ff <= ST_DONE;
                        end else begin
                           bit_ff   <= bit_ff - 1'b1;
                           op_a_ff  <= mm_result;
                           op_b_ff  <= mm_result;
                           start_ff <= 1'b1;
                           phase_ff <= PH_SQUARE;
                        end
                     end
                     PH_MULT: begin
                        acc_ff <= mm_result;
                        if (bit_ff == '0) begin
                           state_ff <= ST_DONE;
                        end else begin
                           bit_ff   <= bit_ff - 1'b1;
                           op_a_ff  <= mm_result;
                           op_b_ff  <= mm_result;
                           start_ff <= 1'b1;
                           phase_ff <= PH_SQUARE;
                        end
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_DONE: begin
               // hand over once the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= acc_ff;
                  rsp_error_ff <= err_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value_out     = rsp_value_ff;
   assign rsp_modulus_error = rsp_error_ff;

endmodule

/* rtl/modexp_checker.sv */
`timescale 1ns / 1ps

module modexp_checker #(
   parameter int WORD_BITS = 32,
   localparam int DATA_W = (WORD_BITS > 32) ? 64 : 32,
   localparam int ADDR_W = ((WORD_BITS > 32) ? 3 : 2) + 1
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [WORD_BITS-1:0] rsp_value_out,
   input logic                 rsp_modulus_error,
   input logic                 psel,
   input logic                 penable,
   input logic                 pwrite,
   input logic [ADDR_W-1:0]    paddr,
   input logic [DATA_W-1:0]    pwdata,
   input logic [DATA_W-1:0]    prdata,
   input logic                 pready
);

   // one word in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after an accepted word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_modulus_error |-> rsp_value_out == '0)
      else $error("modulus error with a nonzero result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_value_out) && $stable(rsp_modulus_error))
      else $error("stalled result word changed or dropped");

   // a register reads back what was just written to it
   assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready)
         ##1 (psel && !pwrite && paddr == $past(paddr))
      |-> prdata[WORD_BITS-1:0] == $past(pwdata[WORD_BITS-1:0]))
      else $error("register readback mismatch");

endmodule

bind modular_exponentiation modexp_checker #(.WORD_BITS(WORD_BITS)) u_modexp_checker (.*);
